@@ src/rxprc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rxprc_pkg;

  localparam logic [7:0]  START_RESET = 8'd70;
  localparam logic [7:0]  STOP_RESET  = 8'd128;
  localparam logic [15:0] HDR_BYTES   = 16'd4;

  // command codes
  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_OVFL = 1'b1;

  // configuration register indexes
  localparam logic REG_START = 1'b0;
  localparam logic REG_STOP  = 1'b1;

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_OK      = 3'd1,
    ST_SKIP    = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_OVFL    = 3'd4
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  current_page;
    logic [15:0] header_length;
    logic [7:0]  header_next_page;
    logic [15:0] max_len;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] header_address;
    logic [15:0] payload_length;
    logic [15:0] first_seg_address;
    logic [15:0] first_seg_length;
    logic [15:0] second_seg_address;
    logic [15:0] second_seg_length;
    logic [7:0]  new_boundary;
  } result_t;

  typedef struct packed {
    logic [7:0] start_page;
    logic [7:0] stop_page;
  } ring_cfg_t;

endpackage

`default_nettype wire

@@ src/rxprc_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rxprc_cfg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [7:0]            cfg_data,
  output rxprc_pkg::ring_cfg_t       ring_cfg
);

  logic [7:0] start_r;
  logic [7:0] start_nxt;
  logic [7:0] stop_r;
  logic [7:0] stop_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    start_nxt = start_r;
    stop_nxt  = stop_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rxprc_pkg::REG_START: start_nxt = cfg_data;
        rxprc_pkg::REG_STOP:  stop_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= rxprc_pkg::START_RESET;
      stop_r  <= rxprc_pkg::STOP_RESET;
    end else begin
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
    end
  end

  assign ring_cfg.start_page = start_r;
  assign ring_cfg.stop_page  = stop_r;

endmodule

`default_nettype wire

@@ src/rxprc_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rxprc_calc (
  input  wire rxprc_pkg::item_t     item,
  input  wire rxprc_pkg::ring_cfg_t ring_cfg,
  input  wire logic [7:0]           boundary,
  output rxprc_pkg::result_t        res
);

  logic [7:0]  page_inc;
  logic [7:0]  page;
  logic [15:0] haddr;
  logic [15:0] dstart;
  logic [15:0] rend;
  logic [15:0] plen;
  logic [16:0] dend;
  logic [15:0] first_len;
  logic [7:0]  next_dec;
  logic [7:0]  stop_dec;
  logic [7:0]  curr_dec;
  logic [7:0]  adv_page;
  logic        corrupt;
  logic        skip;

  assign page_inc  = boundary + 8'd1;
  assign page      = (page_inc >= ring_cfg.stop_page) ? ring_cfg.start_page : page_inc;
  assign haddr     = {page, 8'h00};
  // header sits at a page boundary, so +4 never carries out
  assign dstart    = {page, 8'h04};
  assign rend      = {ring_cfg.stop_page, 8'h00};
  assign plen      = item.header_length - rxprc_pkg::HDR_BYTES;
  assign dend      = {1'b0, dstart} + {1'b0, plen};
  assign first_len = rend - dstart;
  assign next_dec  = item.header_next_page - 8'd1;
  assign stop_dec  = ring_cfg.stop_page - 8'd1;
  assign curr_dec  = item.current_page - 8'd1;
  assign adv_page  = (next_dec < ring_cfg.start_page) ? stop_dec : next_dec;

  assign corrupt = (item.header_length < rxprc_pkg::HDR_BYTES) ||
                   (item.header_next_page > ring_cfg.stop_page) ||
                   (item.header_next_page < ring_cfg.start_page);
  assign skip    = (plen == 16'd0) || (plen > item.max_len);

  always_comb begin
    res              = '0;
    res.status       = rxprc_pkg::ST_EMPTY;
    res.new_boundary = boundary;
    if (item.cmd == rxprc_pkg::CMD_OVFL) begin
      res.status       = rxprc_pkg::ST_OVFL;
      res.new_boundary = (item.current_page == ring_cfg.start_page) ? stop_dec : curr_dec;
    end else if (page != item.current_page) begin
      res.header_address = haddr;
      if (corrupt) begin
        res.status       = rxprc_pkg::ST_CORRUPT;
        res.new_boundary = (item.current_page > ring_cfg.start_page) ? curr_dec : stop_dec;
      end else begin
        res.payload_length = plen;
        res.new_boundary   = adv_page;
        if (skip) begin
          res.status = rxprc_pkg::ST_SKIP;
        end else begin
          res.status            = rxprc_pkg::ST_OK;
          res.first_seg_address = dstart;
          if (dend <= {1'b0, rend}) begin
            res.first_seg_length = plen;
          end else begin
            // packet wraps past the ring end
            res.first_seg_length   = first_len;
            res.second_seg_address = {ring_cfg.start_page, 8'h00};
            res.second_seg_length  = plen - first_len;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/rx_page_ring_consumer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Receive ring consumer: tracks the boundary page of a paged receive ring.
// Input channel (in_*): one transaction per command. A poll (cmd 0) carries
// the receiver's current page and the header fields read at the page after
// the boundary; overflow recovery (cmd 1) needs only current_page.
// Result channel (out_*): exactly one transaction per input transaction, in
// order: status, header address, payload length, up to two read segments
// (split at the ring end) and the boundary page after the command.
// Config channel (cfg_*): index 0 ring start page, index 1 ring stop page;
// always ready, write only while no command is in flight.
// Timing: an accepted command is registered in the input register, and its
// result is then registered in out_r, which raises out_valid.
// Throughput: one command per cycle while out_ready holds; boundary_r loads
// in the same cycle as out_r, so the next command sees it at once.
// If the receiver stalls, the result register holds and the input register
// takes one more command; in_ready drops only when both are full.
// Reset: synchronous active low; boundary returns to page 70, start to 70,
// stop to 128, and both channels come up empty.
module rx_page_ring_consumer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_current_page,
  input  wire logic [15:0] in_header_length,
  input  wire logic [7:0]  in_header_next_page,
  input  wire logic [15:0] in_max_len,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_header_address,
  output logic [15:0]      out_payload_length,
  output logic [15:0]      out_first_seg_address,
  output logic [15:0]      out_first_seg_length,
  output logic [15:0]      out_second_seg_address,
  output logic [15:0]      out_second_seg_length,
  output logic [7:0]       out_new_boundary
);

  rxprc_pkg::ring_cfg_t ring_cfg;
  rxprc_pkg::item_t     item_r;
  rxprc_pkg::result_t   res;
  rxprc_pkg::result_t   out_r;

  logic       in_vld_r;
  logic       in_vld_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic [7:0] boundary_r;
  logic [7:0] boundary_nxt;
  logic       adv;
  logic       in_acc;

  rxprc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ring_cfg  (ring_cfg)
  );

  rxprc_calc u_calc (
    .item     (item_r),
    .ring_cfg (ring_cfg),
    .boundary (boundary_r),
    .res      (res)
  );

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_acc   = in_valid && in_ready;

  assign in_vld_nxt   = in_acc || (in_vld_r && !adv);
  assign out_vld_nxt  = adv || (out_vld_r && !out_ready);
  assign boundary_nxt = adv ? res.new_boundary : boundary_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      boundary_r <= rxprc_pkg::START_RESET;
    end else begin
      in_vld_r   <= in_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      boundary_r <= boundary_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.cmd              <= in_cmd;
      item_r.current_page     <= in_current_page;
      item_r.header_length    <= in_header_length;
      item_r.header_next_page <= in_header_next_page;
      item_r.max_len          <= in_max_len;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_status             = out_r.status;
  assign out_header_address     = out_r.header_address;
  assign out_payload_length     = out_r.payload_length;
  assign out_first_seg_address  = out_r.first_seg_address;
  assign out_first_seg_length   = out_r.first_seg_length;
  assign out_second_seg_address = out_r.second_seg_address;
  assign out_second_seg_length  = out_r.second_seg_length;
  assign out_new_boundary       = out_r.new_boundary;

`ifndef SYNTHESIS
  a_bnd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(boundary_r))
    else $error("boundary moved without a transaction");

  a_bnd_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_vld_r && out_r.new_boundary == boundary_r))
    else $error("reported boundary differs from boundary register");

  a_seg_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == rxprc_pkg::ST_OK) |->
    (16'(out_r.first_seg_length + out_r.second_seg_length) == out_r.payload_length))
    else $error("segment lengths do not add up to payload length");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == rxprc_pkg::ST_EMPTY) |->
    (out_r.header_address == 16'd0 && out_r.first_seg_length == 16'd0))
    else $error("empty ring result carries header data");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with result register free");
`endif

endmodule

`default_nettype wire
